/* design/rmis_pkg.sv */
// ----------------------------------------------------------------------------
// rmis_pkg
// Shared types, codes and constants of the RANSAC inlier scorer.
// ----------------------------------------------------------------------------
package rmis_pkg;

	// default structure sizes
	localparam int DEF_MAX_POINTS = 1024;
	localparam int DEF_COORD_BITS = 16;

	// fixed field widths
	localparam int IDX_W      = 10;
	localparam int CRD_W      = 16;
	localparam int PCNT_W     = 11;
	localparam int TOL_W      = 16;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic              RST_FIT_MODE    = 1'b1;
	localparam logic [PCNT_W-1:0] RST_POINT_COUNT = 11'd1024;
	localparam logic [TOL_W-1:0]  RST_TOLERANCE   = 16'd51;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_HYP,
		OP_QUERY,
		OP_NEWFIT
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK,
		STAT_BAD_SAMPLE,
		STAT_BAD_INDEX
	} stat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIT_MODE,
		CFG_POINT_COUNT,
		CFG_TOLERANCE
	} cfg_idx_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DISPATCH,
		BK_RD1,
		BK_RD2,
		BK_RD3,
		BK_RD_WAIT,
		BK_DIFF,
		BK_CROSS,
		BK_NORM,
		BK_SQ,
		BK_SUM,
		BK_TOL1,
		BK_TOL2,
		BK_SCAN,
		BK_DRAIN,
		BK_FINISH
	} bk_state_t;

	// one classified request as it travels from front to back
	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [CRD_W-1:0]  x;
		logic [CRD_W-1:0]  y;
		logic [CRD_W-1:0]  z;
		logic [IDX_W-1:0]  s1;
		logic [IDX_W-1:0]  s2;
		logic [IDX_W-1:0]  s3;
		stat_t             status;
		logic              plane;
		logic [PCNT_W-1:0] limit;
	} req_t;

endpackage

/* design/ransac_model_inlier_scorer.sv */
// ----------------------------------------------------------------------------
// ransac_model_inlier_scorer
// Scores line or plane hypotheses over a stored Q8.8 point cloud.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start while busy is low: load point, test hypothesis,
//   query best-set mark, start new fit. A two-entry queue sits between the
//   front (registers, checks) and the back (store, scan), so a request can
//   be taken while the back is still working.
//   Each request gives exactly one result, shown for one cycle with done high.
//   Load, new fit, query and a rejected hypothesis skip the scan.
//   A hypothesis first reads the three samples and builds the normal in
//   the setup states, then the scan reads one point per cycle through the
//   single read port of the point store, and the five-stage distance
//   pipeline drains before the result.
//   Configuration writes go through cfg_we / cfg_index / cfg_data and take
//   effect at once; write them only while no request is outstanding.
//   Reset clears the best set and count and restores register defaults;
//   the point store holds nothing defined until loaded.
//   Results cannot be held off: the receiver must take done when it shows.
// ----------------------------------------------------------------------------
module ransac_model_inlier_scorer import rmis_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              opcode,
	input  logic [IDX_W-1:0]        point_index,
	input  logic signed [CRD_W-1:0] coord_x,
	input  logic signed [CRD_W-1:0] coord_y,
	input  logic signed [CRD_W-1:0] coord_z,
	input  logic [IDX_W-1:0]        sample_one,
	input  logic [IDX_W-1:0]        sample_two,
	input  logic [IDX_W-1:0]        sample_three,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic                    done,
	output logic [STAT_W-1:0]       status,
	output logic [PCNT_W-1:0]       hypothesis_count,
	output logic                    became_best,
	output logic [PCNT_W-1:0]       best_count,
	output logic                    is_inlier
);

	logic             q_full, q_valid, q_pop, push;
	req_t             push_req, q_head;
	logic [TOL_W-1:0] tol;

	// request intake and classification
	rmis_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.point_index(point_index), .coord_x(coord_x), .coord_y(coord_y),
		.coord_z(coord_z), .sample_one(sample_one), .sample_two(sample_two),
		.sample_three(sample_three), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .q_full(q_full), .busy(busy), .push(push),
		.push_req(push_req), .tol(tol)
	);

	// decoupling queue
	rmis_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_req(push_req),
		.pop(q_pop), .full(q_full), .valid(q_valid), .head(q_head)
	);

	// execution
	rmis_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head),
		.q_pop(q_pop), .tol(tol), .done(done), .status(status),
		.hypothesis_count(hypothesis_count), .became_best(became_best),
		.best_count(best_count), .is_inlier(is_inlier)
	);

endmodule

/* design/rmis_front.sv */
// ----------------------------------------------------------------------------
// rmis_front
// Configuration registers and request classification ahead of the queue.
// ----------------------------------------------------------------------------
module rmis_front import rmis_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            opcode,
	input  logic [IDX_W-1:0]      point_index,
	input  logic signed [CRD_W-1:0] coord_x,
	input  logic signed [CRD_W-1:0] coord_y,
	input  logic signed [CRD_W-1:0] coord_z,
	input  logic [IDX_W-1:0]      sample_one,
	input  logic [IDX_W-1:0]      sample_two,
	input  logic [IDX_W-1:0]      sample_three,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_full,
	output logic                  busy,
	output logic                  push,
	output req_t                  push_req,
	output logic [TOL_W-1:0]      tol
);

	logic              fit_mode_q;
	logic [PCNT_W-1:0] point_count_q;
	logic [TOL_W-1:0]  tol_q;
	logic [PCNT_W-1:0] limit;
	logic              bad;
	stat_t             st;
	op_t               op;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= RST_FIT_MODE;
			point_count_q <= RST_POINT_COUNT;
			tol_q         <= RST_TOLERANCE;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FIT_MODE:    fit_mode_q    <= cfg_data[0];
				CFG_POINT_COUNT: point_count_q <= cfg_data[PCNT_W-1:0];
				CFG_TOLERANCE:   tol_q         <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// effective scan length and sample checks
	assign op    = op_t'(opcode);
	assign limit = (32'(point_count_q) > MAX_POINTS) ? PCNT_W'(MAX_POINTS) : point_count_q;
	assign bad   = (PCNT_W'(sample_one) >= limit) || (PCNT_W'(sample_two) >= limit) ||
	               (sample_one == sample_two) ||
	               (fit_mode_q && ((PCNT_W'(sample_three) >= limit) ||
	                               (sample_three == sample_one) ||
	                               (sample_three == sample_two)));

	always_comb begin
		st = STAT_OK;
		case (op)
			OP_LOAD, OP_QUERY: begin
				if (32'(point_index) >= MAX_POINTS)
					st = STAT_BAD_INDEX;
			end
			OP_HYP: begin
				if (bad)
					st = STAT_BAD_SAMPLE;
			end
			default: ;
		endcase
	end

	// request into the queue
	assign busy = q_full;
	assign push = start && !q_full;
	assign tol  = tol_q;

	always_comb begin
		push_req.op     = op;
		push_req.idx    = point_index;
		push_req.x      = coord_x;
		push_req.y      = coord_y;
		push_req.z      = coord_z;
		push_req.s1     = sample_one;
		push_req.s2     = sample_two;
		push_req.s3     = sample_three;
		push_req.status = st;
		push_req.plane  = fit_mode_q;
		push_req.limit  = limit;
	end

endmodule

/* design/rmis_queue.sv */
// ----------------------------------------------------------------------------
// rmis_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module rmis_queue import rmis_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	input  logic pop,
	output logic full,
	output logic valid,
	output req_t head
);

	req_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_req;
	end

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign head  = ent_q[rd_q];

endmodule

/* design/rmis_back.sv */
// ----------------------------------------------------------------------------
// rmis_back
// Executes requests: point store, model setup, scan pipeline, best set.
// ----------------------------------------------------------------------------
module rmis_back import rmis_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  req_t              q_head,
	output logic              q_pop,
	input  logic [TOL_W-1:0]  tol,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [PCNT_W-1:0] hypothesis_count,
	output logic              became_best,
	output logic [PCNT_W-1:0] best_count,
	output logic              is_inlier
);

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;
	localparam int NW  = 2 * DW + 1;
	localparam int UW  = NW + DW + 2;
	localparam int H   = (UW + 1) / 2;
	localparam int SH  = (NW + 1) / 2;
	localparam int N2W = 2 * NW + 2;
	localparam int NH  = (N2W + 1) / 2;
	localparam int TW  = 2 * TOL_W;
	localparam int T2W = N2W + TW;
	localparam int CW  = (2 * UW > T2W) ? 2 * UW : T2W;

	bk_state_t state_q, state_d;
	req_t      cur_q;

	// point store and mark store
	logic [C-1:0]  px_mem [MAX_POINTS];
	logic [C-1:0]  py_mem [MAX_POINTS];
	logic [C-1:0]  pz_mem [MAX_POINTS];
	logic [C-1:0]  rx_q, ry_q, rz_q;
	logic          pt_we;
	logic [AW-1:0] pt_raddr;
	logic          mark_mem [2*MAX_POINTS];
	logic          mk_rd_q;
	logic          mk_we;
	logic [AW:0]   mk_waddr;
	logic          mk_wdata;

	// model setup registers
	logic [C-1:0]           x1_q, y1_q, z1_q, x2_q, y2_q, z2_q, x3_q, y3_q, z3_q;
	logic signed [DW-1:0]   u_q [3];
	logic signed [DW-1:0]   v_q [3];
	logic signed [2*DW-1:0] m_q [6];
	logic signed [NW-1:0]   nrm_q [3];
	logic [NW-1:0]          nmag [3];
	logic [2*(NW-SH)-1:0]   nhh_q [3];
	logic [NW-1:0]          nhl_q [3];
	logic [2*SH-1:0]        nll_q [3];
	logic [N2W-1:0]         norm2_q;
	logic                   nonzero_q;
	logic [TW-1:0]          tol2_q;
	logic [N2W-NH+TW-1:0]   th_q;
	logic [NH+TW-1:0]       tl_q;
	logic [CW-1:0]          tol2n_q;

	// scan pipeline registers
	logic [PCNT_W-1:0]         scan_q;
	logic [PCNT_W-1:0]         cnt_q;
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [PCNT_W-1:0]         idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic signed [DW-1:0]      dx_s2 [3];
	logic signed [NW+DW-1:0]   prod_s3 [3];
	logic [UW-1:0]             mag_s4;
	logic [2*(UW-H)-1:0]       hh_s5;
	logic [UW-1:0]             hl_s5;
	logic [2*H-1:0]            ll_s5;
	logic signed [UW-1:0]      numsum;
	logic [CW-1:0]             sq;
	logic                      hit;
	logic                      forced;

	// best set bookkeeping
	logic [PCNT_W-1:0] best_total_q;
	logic [PCNT_W-1:0] best_limit_q;
	logic              best_bank_q;
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [PCNT_W-1:0] hcnt_q;
	logic              bb_q;
	logic              inl_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	// next state and queue pop
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_DISPATCH;
				end
			end
			BK_DISPATCH: begin
				if (cur_q.op == OP_HYP && cur_q.status == STAT_OK)
					state_d = BK_RD1;
				else
					state_d = BK_FINISH;
			end
			BK_RD1:     state_d = BK_RD2;
			BK_RD2:     state_d = BK_RD3;
			BK_RD3:     state_d = BK_RD_WAIT;
			BK_RD_WAIT: state_d = BK_DIFF;
			BK_DIFF:    state_d = BK_CROSS;
			BK_CROSS:   state_d = BK_NORM;
			BK_NORM:    state_d = BK_SQ;
			BK_SQ:      state_d = BK_SUM;
			BK_SUM:     state_d = BK_TOL1;
			BK_TOL1:    state_d = BK_TOL2;
			BK_TOL2:    state_d = BK_SCAN;
			BK_SCAN: begin
				if (scan_q == cur_q.limit - PCNT_W'(1))
					state_d = BK_DRAIN;
			end
			BK_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3 || v_s4 || v_s5))
					state_d = BK_FINISH;
			end
			BK_FINISH:  state_d = BK_IDLE;
			default:    state_d = BK_IDLE;
		endcase
	end

	// point store port selection
	always_comb begin
		case (state_q)
			BK_RD2:  pt_raddr = AW'(cur_q.s2);
			BK_RD3:  pt_raddr = AW'(cur_q.s3);
			BK_SCAN: pt_raddr = AW'(scan_q);
			default: pt_raddr = AW'(cur_q.s1);
		endcase
	end

	assign pt_we = (state_q == BK_FINISH) && (cur_q.op == OP_LOAD) && (cur_q.status == STAT_OK);

	always_ff @(posedge clk) begin
		if (pt_we) begin
			px_mem[AW'(cur_q.idx)] <= C'(cur_q.x);
			py_mem[AW'(cur_q.idx)] <= C'(cur_q.y);
			pz_mem[AW'(cur_q.idx)] <= C'(cur_q.z);
		end
		rx_q <= px_mem[pt_raddr];
		ry_q <= py_mem[pt_raddr];
		rz_q <= pz_mem[pt_raddr];
	end

	// mark store: trial marks go to the bank not holding the best set
	always_ff @(posedge clk) begin
		if (mk_we)
			mark_mem[mk_waddr] <= mk_wdata;
		mk_rd_q <= mark_mem[{best_bank_q, AW'(cur_q.idx)}];
	end

	// per-point distance test at the end of the scan pipeline
	always_comb begin
		numsum = UW'(prod_s3[0]) + UW'(prod_s3[1]) + UW'(prod_s3[2]);
		sq     = (CW'(hh_s5) << (2 * H)) + (CW'(hl_s5) << (H + 1)) + CW'(ll_s5);
		hit    = nonzero_q && (sq <= tol2n_q);
		forced = cur_q.plane && ((idx_s5 == PCNT_W'(cur_q.s1)) ||
		                         (idx_s5 == PCNT_W'(cur_q.s2)) ||
		                         (idx_s5 == PCNT_W'(cur_q.s3)));
		mk_we    = v_s5;
		mk_waddr = {~best_bank_q, AW'(idx_s5)};
		mk_wdata = forced || hit;
		for (int k = 0; k < 3; k++)
			nmag[k] = nrm_q[k][NW-1] ? NW'(-nrm_q[k]) : NW'(nrm_q[k]);
	end

	// model setup datapath
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_head;
		case (state_q)
			BK_RD2: begin
				x1_q <= rx_q; y1_q <= ry_q; z1_q <= rz_q;
			end
			BK_RD3: begin
				x2_q <= rx_q; y2_q <= ry_q; z2_q <= rz_q;
			end
			BK_RD_WAIT: begin
				x3_q <= rx_q; y3_q <= ry_q; z3_q <= rz_q;
			end
			BK_DIFF: begin
				u_q[0] <= DW'($signed(x2_q)) - DW'($signed(x1_q));
				u_q[1] <= DW'($signed(y2_q)) - DW'($signed(y1_q));
				u_q[2] <= DW'($signed(z2_q)) - DW'($signed(z1_q));
				v_q[0] <= DW'($signed(x3_q)) - DW'($signed(x1_q));
				v_q[1] <= DW'($signed(y3_q)) - DW'($signed(y1_q));
				v_q[2] <= DW'($signed(z3_q)) - DW'($signed(z1_q));
				tol2_q <= TW'(tol) * TW'(tol);
			end
			BK_CROSS: begin
				m_q[0] <= u_q[1] * v_q[2];
				m_q[1] <= u_q[2] * v_q[1];
				m_q[2] <= u_q[2] * v_q[0];
				m_q[3] <= u_q[0] * v_q[2];
				m_q[4] <= u_q[0] * v_q[1];
				m_q[5] <= u_q[1] * v_q[0];
			end
			BK_NORM: begin
				if (cur_q.plane) begin
					nrm_q[0] <= NW'(m_q[0]) - NW'(m_q[1]);
					nrm_q[1] <= NW'(m_q[2]) - NW'(m_q[3]);
					nrm_q[2] <= NW'(m_q[4]) - NW'(m_q[5]);
				end else begin
					nrm_q[0] <= -NW'(u_q[1]);
					nrm_q[1] <= NW'(u_q[0]);
					nrm_q[2] <= '0;
				end
			end
			BK_SQ: begin
				for (int k = 0; k < 3; k++) begin
					nhh_q[k] <= (2*(NW-SH))'(nmag[k][NW-1:SH]) * (2*(NW-SH))'(nmag[k][NW-1:SH]);
					nhl_q[k] <= NW'(nmag[k][NW-1:SH]) * NW'(nmag[k][SH-1:0]);
					nll_q[k] <= (2*SH)'(nmag[k][SH-1:0]) * (2*SH)'(nmag[k][SH-1:0]);
				end
			end
			BK_SUM: begin
				norm2_q <= (N2W'(nhh_q[0]) << (2 * SH)) + (N2W'(nhl_q[0]) << (SH + 1)) +
				           N2W'(nll_q[0]) +
				           (N2W'(nhh_q[1]) << (2 * SH)) + (N2W'(nhl_q[1]) << (SH + 1)) +
				           N2W'(nll_q[1]) +
				           (N2W'(nhh_q[2]) << (2 * SH)) + (N2W'(nhl_q[2]) << (SH + 1)) +
				           N2W'(nll_q[2]);
			end
			BK_TOL1: begin
				nonzero_q <= norm2_q != '0;
				th_q <= (N2W-NH+TW)'(norm2_q[N2W-1:NH]) * (N2W-NH+TW)'(tol2_q);
				tl_q <= (NH+TW)'(norm2_q[NH-1:0]) * (NH+TW)'(tol2_q);
			end
			BK_TOL2: begin
				tol2n_q <= (CW'(th_q) << NH) + CW'(tl_q);
			end
			default: ;
		endcase

		// scan pipeline payload
		idx_s1 <= scan_q;
		idx_s2 <= idx_s1;
		dx_s2[0] <= DW'($signed(rx_q)) - DW'($signed(x1_q));
		dx_s2[1] <= DW'($signed(ry_q)) - DW'($signed(y1_q));
		dx_s2[2] <= DW'($signed(rz_q)) - DW'($signed(z1_q));
		idx_s3 <= idx_s2;
		for (int k = 0; k < 3; k++)
			prod_s3[k] <= nrm_q[k] * dx_s2[k];
		idx_s4 <= idx_s3;
		mag_s4 <= numsum[UW-1] ? UW'(-numsum) : UW'(numsum);
		idx_s5 <= idx_s4;
		hh_s5  <= (2*(UW-H))'(mag_s4[UW-1:H]) * (2*(UW-H))'(mag_s4[UW-1:H]);
		hl_s5  <= UW'(mag_s4[UW-1:H]) * UW'(mag_s4[H-1:0]);
		ll_s5  <= (2*H)'(mag_s4[H-1:0]) * (2*H)'(mag_s4[H-1:0]);

		// result payload
		if (state_q == BK_FINISH) begin
			status_q <= cur_q.status;
			hcnt_q   <= '0;
			inl_q    <= 1'b0;
			if (cur_q.status == STAT_OK) begin
				case (cur_q.op)
					OP_HYP:   hcnt_q <= cnt_q;
					OP_QUERY: inl_q  <= mk_rd_q && (PCNT_W'(cur_q.idx) < best_limit_q);
					default: ;
				endcase
			end
		end
	end

	// scan control, count and best set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			cnt_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			best_total_q <= '0;
			best_limit_q <= '0;
			best_bank_q  <= 1'b0;
			done_q       <= 1'b0;
			bb_q         <= 1'b0;
		end else begin
			v_s1 <= state_q == BK_SCAN;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (state_q == BK_TOL2) begin
				scan_q <= '0;
				cnt_q  <= '0;
			end else begin
				if (state_q == BK_SCAN)
					scan_q <= scan_q + PCNT_W'(1);
				if (v_s5)
					cnt_q <= cnt_q + PCNT_W'(mk_wdata);
			end
			done_q <= state_q == BK_FINISH;
			bb_q   <= 1'b0;
			if (state_q == BK_FINISH) begin
				if (cur_q.op == OP_HYP && cur_q.status == STAT_OK && cnt_q > best_total_q) begin
					best_total_q <= cnt_q;
					best_limit_q <= cur_q.limit;
					best_bank_q  <= ~best_bank_q;
					bb_q         <= 1'b1;
				end else if (cur_q.op == OP_NEWFIT) begin
					best_total_q <= '0;
					best_limit_q <= '0;
				end
			end
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign hypothesis_count = hcnt_q;
	assign became_best      = bb_q;
	assign best_count       = best_total_q;
	assign is_inlier        = inl_q;

endmodule

/* design/rmis_checker.sv */
// ----------------------------------------------------------------------------
// rmis_checker
// Port-level checks of the inlier scorer, bound to the top level.
// ----------------------------------------------------------------------------
module rmis_checker import rmis_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              done,
	input logic [STAT_W-1:0] status,
	input logic [PCNT_W-1:0] hypothesis_count,
	input logic              became_best,
	input logic [PCNT_W-1:0] best_count,
	input logic              is_inlier
);

	// results never come in adjacent cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");

	// a new best carries its own count
	a_best_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && became_best) |-> (status == STAT_OK && hypothesis_count == best_count))
		else $error("best count mismatch");

	// a rejected request reports nothing else
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (hypothesis_count == '0 && !became_best && !is_inlier))
		else $error("rejected request with payload");

	// a marked point implies a nonempty best set
	a_inlier: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_inlier) |-> (best_count != '0)) else $error("mark without best set");

endmodule

bind ransac_model_inlier_scorer rmis_checker u_rmis_checker (.*);
